[rtl/core/ipsr_pkg.sv]
// ----------------------------------------------------------------------------
// ipsr_pkg
// Shared types and constants of the IR probe and send retry core.
// ----------------------------------------------------------------------------
package ipsr_pkg;

    localparam int PACKET_BYTES = 3;
    localparam int BYTE_IDX_W   = $clog2(PACKET_BYTES);

    localparam logic [7:0] MARK_B   = 8'h42;
    localparam logic [7:0] BYTE_FF  = 8'hFF;

    // Input op codes
    localparam logic [2:0] OP_CHECK = 3'd0;
    localparam logic [2:0] OP_SEND  = 3'd1;
    localparam logic [2:0] OP_REPLY = 3'd2;
    localparam logic [2:0] OP_TICK  = 3'd3;
    localparam logic [2:0] OP_ABORT = 3'd4;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Configuration register indexes
    localparam int         CFG_IDX_W          = 1;
    localparam logic [0:0] CFG_RETRY_INTERVAL = 1'b0;
    localparam logic [0:0] CFG_MAX_RETRIES    = 1'b1;

    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd150;
    localparam logic [3:0]  MAX_RETRIES_RST    = 4'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] new_bright;
        logic [7:0] new_number;
        logic [7:0] reply_first;
        logic [7:0] reply_second;
    } ipsr_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic       success;
        logic       job_was_send;
        logic [7:0] stored_bright_out;
        logic [7:0] stored_number_out;
    } ipsr_result_t;

    // Work handed from the front to the back: a whole packet or a completion
    typedef struct packed {
        logic       is_packet;
        logic       ok;
        logic       job_send;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] remote_bright;
        logic [7:0] remote_number;
    } ipsr_cmd_t;

endpackage

[rtl/core/ipsr_front.sv]
// ----------------------------------------------------------------------------
// ipsr_front
// Job state machine: takes one input item a cycle while accept is high and
// issues packet or completion commands.
// ----------------------------------------------------------------------------
module ipsr_front
    import ipsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ipsr_item_t           item,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 cmd_valid,
    output ipsr_cmd_t            cmd
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PROBE = 3'b010,
        PH_SEND  = 3'b100
    } ipsr_phase_t;

    ipsr_phase_t phase_reg, phase_next;
    logic        is_send_reg, is_send_next;
    logic [3:0]  retries_reg, retries_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  pend_bright_reg, pend_bright_next;
    logic [7:0]  pend_number_reg, pend_number_next;
    logic [7:0]  rem_bright_reg, rem_bright_next;
    logic [7:0]  rem_number_reg, rem_number_next;
    logic [15:0] interval_reg;
    logic [3:0]  max_retries_reg;

    logic        busy;
    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic        emit_pkt;
    logic        emit_done;
    logic        done_ok;

    assign busy     = (phase_reg != PH_IDLE);
    assign tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign limit    = (interval_reg == 16'd0) ? 16'd1 : interval_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        is_send_next     = is_send_reg;
        retries_next     = retries_reg;
        tick_next        = tick_reg;
        pend_bright_next = pend_bright_reg;
        pend_number_next = pend_number_reg;
        rem_bright_next  = rem_bright_reg;
        rem_number_next  = rem_number_reg;
        emit_pkt         = 1'b0;
        emit_done        = 1'b0;
        done_ok          = 1'b0;
        if (accept)
        begin
            case (item.op)
                OP_CHECK, OP_SEND:
                begin
                    if (!busy)
                    begin
                        if (item.op == OP_SEND)
                        begin
                            pend_bright_next = item.new_bright;
                            pend_number_next = item.new_number;
                        end
                        is_send_next = (item.op == OP_SEND);
                        phase_next   = PH_PROBE;
                        retries_next = max_retries_reg;
                        tick_next    = 16'd0;
                        emit_pkt     = 1'b1;
                    end
                end
                OP_REPLY:
                begin
                    if (busy)
                    begin
                        rem_bright_next = item.reply_first;
                        rem_number_next = item.reply_second;
                        if (phase_reg == PH_PROBE && is_send_reg)
                        begin
                            phase_next   = PH_SEND;
                            retries_next = max_retries_reg;
                            tick_next    = 16'd0;
                            emit_pkt     = 1'b1;
                        end
                        else
                        begin
                            phase_next   = PH_IDLE;
                            retries_next = 4'd0;
                            tick_next    = 16'd0;
                            emit_done    = 1'b1;
                            done_ok      = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (busy)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= limit)
                        begin
                            tick_next = 16'd0;
                            if (retries_reg == 4'd0)
                            begin
                                phase_next   = PH_IDLE;
                                retries_next = 4'd0;
                                emit_done    = 1'b1;
                            end
                            else
                            begin
                                retries_next = retries_reg - 4'd1;
                                emit_pkt     = 1'b1;
                            end
                        end
                    end
                end
                OP_ABORT:
                begin
                    if (busy)
                    begin
                        phase_next   = PH_IDLE;
                        retries_next = 4'd0;
                        tick_next    = 16'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Probe packets carry 255,255; send packets carry the pending bytes
    assign cmd_valid         = emit_pkt | emit_done;
    assign cmd.is_packet     = emit_pkt;
    assign cmd.ok            = done_ok;
    assign cmd.job_send      = is_send_next;
    assign cmd.byte1         = (phase_next == PH_PROBE) ? BYTE_FF : pend_bright_next;
    assign cmd.byte2         = (phase_next == PH_PROBE) ? BYTE_FF : pend_number_next;
    assign cmd.remote_bright = rem_bright_next;
    assign cmd.remote_number = rem_number_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            is_send_reg     <= 1'b0;
            retries_reg     <= 4'd0;
            tick_reg        <= 16'd0;
            pend_bright_reg <= BYTE_FF;
            pend_number_reg <= BYTE_FF;
            rem_bright_reg  <= BYTE_FF;
            rem_number_reg  <= BYTE_FF;
            interval_reg    <= RETRY_INTERVAL_RST;
            max_retries_reg <= MAX_RETRIES_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            is_send_reg     <= is_send_next;
            retries_reg     <= retries_next;
            tick_reg        <= tick_next;
            pend_bright_reg <= pend_bright_next;
            pend_number_reg <= pend_number_next;
            rem_bright_reg  <= rem_bright_next;
            rem_number_reg  <= rem_number_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_RETRY_INTERVAL: interval_reg    <= cfg_data;
                    CFG_MAX_RETRIES:    max_retries_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

[rtl/core/ipsr_queue.sv]
// ----------------------------------------------------------------------------
// ipsr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ipsr_queue
    import ipsr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  ipsr_cmd_t wr_data,
    input  logic      rd,
    output logic      not_empty,
    output logic      is_full,
    output ipsr_cmd_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ipsr_cmd_t         mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign do_wr     = wr & ~is_full;
    assign do_rd     = rd & not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/ipsr_back.sv]
// ----------------------------------------------------------------------------
// ipsr_back
// Result serializer: expands one command into its result items, one per pop.
// ----------------------------------------------------------------------------
module ipsr_back
    import ipsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_avail,
    input  ipsr_cmd_t    cmd,
    output logic         cmd_take,
    output logic         empty,
    input  logic         pop,
    output ipsr_result_t result
);

    ipsr_cmd_t             cur_reg;
    logic                  busy_reg, busy_next;
    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  cur_last;
    logic                  xfer;

    assign cur_last = ~cur_reg.is_packet | (idx_reg == BYTE_IDX_W'(PACKET_BYTES - 1));
    assign xfer     = pop & busy_reg;
    assign empty    = ~busy_reg;
    // Load the next command when the slot is free or its final result leaves
    assign cmd_take = cmd_avail & (~busy_reg | (xfer & cur_last));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (cmd_take)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (xfer)
        begin
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + BYTE_IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        result.kind              = cur_reg.is_packet ? KIND_TX : KIND_DONE;
        result.last              = cur_last;
        result.success           = cur_reg.ok;
        result.job_was_send      = cur_reg.job_send;
        result.stored_bright_out = cur_reg.remote_bright;
        result.stored_number_out = cur_reg.remote_number;
        result.tx_byte           = 8'd0;
        if (cur_reg.is_packet)
        begin
            case (idx_reg)
                BYTE_IDX_W'(0): result.tx_byte = MARK_B;
                BYTE_IDX_W'(1): result.tx_byte = cur_reg.byte1;
                default:        result.tx_byte = cur_reg.byte2;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

[rtl/core/ir_probe_and_send_retry_core.sv]
// ----------------------------------------------------------------------------
// ir_probe_and_send_retry_core
// Request and retry engine for an IR link: probe, send and timeout handling.
// ----------------------------------------------------------------------------
// Path: an item is classified by the front, held in the command queue and
//   then loaded into the result register of the back; a busy back holds it.
// Throughput: one item per cycle into the front while the queue is not full;
//   a packet drains at one byte per pop, set by the single result register of the back.
// Reset: rst_n clears job state, queue pointers and the busy flag of the back
//   at once; registers return to interval 150 and 4 retries.
// ----------------------------------------------------------------------------
module ir_probe_and_send_retry_core
    import ipsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input queue side
    input  logic                 push,
    output logic                 full,
    input  ipsr_item_t           item,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output ipsr_result_t         result,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic      accept;
    logic      cfg_wr;
    logic      cmd_valid;
    ipsr_cmd_t cmd;
    logic      q_not_empty;
    logic      q_full;
    ipsr_cmd_t q_data;
    logic      q_take;

    // Registers take a write in any cycle; a new interval applies at once,
    // a new retry count from the next phase start.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // Hold off input whenever the command queue cannot take a command.
    // Items that produce nothing still wait, which keeps order trivially.
    assign full   = q_full;
    assign accept = push & ~q_full;

    // Front: update job state and classify each item in its accept cycle.
    ipsr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // Queue: decouple job handling from a stalled result consumer.
    ipsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (cmd_valid),
        .wr_data   (cmd),
        .rd        (q_take),
        .not_empty (q_not_empty),
        .is_full   (q_full),
        .rd_data   (q_data)
    );

    // Back: expand each command into its result transfers.
    ipsr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (q_not_empty),
        .cmd       (q_data),
        .cmd_take  (q_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // A packet that is not finished keeps the result side non-empty.
    a_packet_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last) |=> !empty)
        else $error("result stream broke inside a packet");

    // A byte that is not last is followed by another transmit byte.
    a_packet_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last) |=> (result.kind == KIND_TX))
        else $error("packet interrupted by a completion report");

    // Completion reports are always single and final.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_DONE) |-> (result.last && result.tx_byte == 8'd0))
        else $error("completion report malformed");

endmodule
